[hdl/frdr_pkg.sv]
// Shared types and constants for the frame dedup / reassembly core.
// Used by frdr_seq_filter, frdr_asm_tracker and frame_dedup_reassembler_core.
package frdr_pkg;

   localparam int MAX_DEVICES_DEF   = 64;
   localparam int MAX_FRAGMENTS_DEF = 10;
   localparam int CHUNK_BYTES_DEF   = 25;

   localparam logic [7:0] HEARTBEAT_INDEX = 8'hFF;
   localparam logic [7:0] IDLE_SOURCE     = 8'hFF;

   typedef enum logic [2:0] {
      VERDICT_CRC    = 3'd0,
      VERDICT_DUP    = 3'd1,
      VERDICT_HB     = 3'd2,
      VERDICT_BAD    = 3'd3,
      VERDICT_STORED = 3'd4,
      VERDICT_READY  = 3'd5
   } verdict_type;

   typedef struct packed {
      logic       crc_ok;
      logic [7:0] source_dev;
      logic [7:0] seq_num;
      logic [7:0] frag_index;
      logic [7:0] frag_count;
      logic [7:0] payload_len;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic        clear_buffer;
      logic        store_payload;
      logic [7:0]  buffer_offset;
      logic        from_buffer;
      logic [7:0]  message_length;
   } rsp_type;

   // Pipeline control handed from the top level to the state holders.
   typedef struct packed {
      logic accept;   // header transaction taken into the lookup stage
      logic commit;   // header in the lookup stage moves on, state updates
   } stage_ctl_type;

endpackage

[hdl/frdr_seq_filter.sv]
// Per-device last-sequence memory with known bits and a write bypass.
// Depends on frdr_pkg.
module frdr_seq_filter #(
   parameter int MaxDevices = frdr_pkg::MAX_DEVICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  frdr_pkg::stage_ctl_type ctl,
   input  frdr_pkg::req_type     req_item,
   input  frdr_pkg::req_type     s1_item,
   output logic                  dup
);

   localparam int DevAw = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;
   localparam logic [8:0] MaxDevW = 9'(MaxDevices);

   logic [7:0]            seq_mem_ff [MaxDevices];
   logic [MaxDevices-1:0] known_ff;
   logic [7:0]            rd_ff;
   logic                  byp_hit_ff;
   logic [7:0]            byp_data_ff;

   logic             rd_tracked;
   logic [DevAw-1:0] rd_addr;
   logic             s1_tracked;
   logic [DevAw-1:0] s1_addr;
   logic [7:0]       last_seq;
   logic             wr_en;

   assign rd_tracked = {1'b0, req_item.source_dev} < MaxDevW;
   assign rd_addr    = req_item.source_dev[DevAw-1:0];
   assign s1_tracked = {1'b0, s1_item.source_dev} < MaxDevW;
   assign s1_addr    = s1_item.source_dev[DevAw-1:0];

   // Take the value that was being written when this read was taken, if that write hit the same entry
   assign last_seq = byp_hit_ff ? byp_data_ff : rd_ff;
   assign dup      = s1_tracked && known_ff[s1_addr] && (last_seq == s1_item.seq_num);
   assign wr_en    = ctl.commit && s1_item.crc_ok && s1_tracked && !dup;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem_ff[s1_addr] <= s1_item.seq_num;
      end
      if (ctl.accept) begin
         rd_ff       <= seq_mem_ff[rd_addr];
         byp_hit_ff  <= wr_en && rd_tracked && (s1_addr == rd_addr);
         byp_data_ff <= s1_item.seq_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else if (wr_en) begin
         known_ff[s1_addr] <= 1'b1;
      end
   end

`ifndef SYNTH
   a_write_tracked : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_tracked && !dup)
      else $error("sequence write for untracked device or duplicate");
   a_known_after_write : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> known_ff[$past(s1_addr)])
      else $error("known bit not set after sequence write");
   a_dup_needs_known : assert property (@(posedge clock) disable iff (reset)
      dup |-> known_ff[s1_addr])
      else $error("duplicate flagged on unknown device");
`endif

endmodule

[hdl/frdr_asm_tracker.sv]
// Reassembly tracker: verdict decode and single-message fragment bookkeeping.
// Depends on frdr_pkg.
module frdr_asm_tracker #(
   parameter int MaxFragments = frdr_pkg::MAX_FRAGMENTS_DEF,
   parameter int ChunkBytes   = frdr_pkg::CHUNK_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  frdr_pkg::stage_ctl_type ctl,
   input  frdr_pkg::req_type       item,
   input  logic                    dup,
   output frdr_pkg::rsp_type       result
);

   localparam int BufBytes = MaxFragments * ChunkBytes;
   localparam int FragAw   = $clog2(MaxFragments);
   localparam int CntW     = $clog2(MaxFragments + 1);
   localparam int LenW     = $clog2(BufBytes + 1);
   localparam int SumW     = $clog2(BufBytes + 256);
   localparam logic [8:0]      MaxFragW = 9'(MaxFragments);
   localparam logic [SumW-1:0] BufW     = SumW'(BufBytes);

   logic [7:0]              asm_source_ff, asm_source_in;
   logic [7:0]              asm_total_ff,  asm_total_in;
   logic [MaxFragments-1:0] asm_mask_ff,   asm_mask_in;
   logic [CntW-1:0]         asm_count_ff,  asm_count_in;
   logic [LenW-1:0]         asm_length_ff, asm_length_in;

   logic              is_bad;
   logic [FragAw-1:0] idx_lo;
   logic [SumW-1:0]   offset;
   logic [SumW-1:0]   chunk_end;
   logic              fits;

   assign is_bad    = ({1'b0, item.frag_count} > MaxFragW) || (item.frag_index >= item.frag_count);
   assign idx_lo    = item.frag_index[FragAw-1:0];
   assign offset    = SumW'(idx_lo) * SumW'(ChunkBytes);
   assign chunk_end = offset + SumW'(item.payload_len);
   assign fits      = chunk_end <= BufW;

   always_comb begin
      result         = '0;
      result.verdict = frdr_pkg::VERDICT_CRC;
      asm_source_in  = asm_source_ff;
      asm_total_in   = asm_total_ff;
      asm_mask_in    = asm_mask_ff;
      asm_count_in   = asm_count_ff;
      asm_length_in  = asm_length_ff;
      if (!item.crc_ok) begin
         result.verdict = frdr_pkg::VERDICT_CRC;
      end else if (dup) begin
         result.verdict = frdr_pkg::VERDICT_DUP;
      end else if (item.frag_index == frdr_pkg::HEARTBEAT_INDEX) begin
         result.verdict = frdr_pkg::VERDICT_HB;
      end else if (is_bad) begin
         result.verdict = frdr_pkg::VERDICT_BAD;
      end else if (item.frag_count == 8'd1) begin
         result.verdict        = frdr_pkg::VERDICT_READY;
         result.message_length = (SumW'(item.payload_len) > BufW) ? 8'(BufBytes)
                                                                   : item.payload_len;
      end else begin
         // Restart on a new source or a new fragment total
         if ((asm_source_ff != item.source_dev) || (asm_total_ff != item.frag_count)) begin
            asm_source_in       = item.source_dev;
            asm_total_in        = item.frag_count;
            asm_mask_in         = '0;
            asm_count_in        = '0;
            asm_length_in       = '0;
            result.clear_buffer = 1'b1;
         end
         if (fits) begin
            result.store_payload = 1'b1;
            result.buffer_offset = 8'(offset);
            if (item.frag_index == item.frag_count - 8'd1) begin
               asm_length_in = LenW'(chunk_end);
            end
            if (!asm_mask_in[idx_lo]) begin
               asm_count_in = CntW'(asm_count_in + 1'b1);
            end
            asm_mask_in[idx_lo] = 1'b1;
         end
         if (8'(asm_count_in) >= asm_total_in) begin
            result.verdict        = frdr_pkg::VERDICT_READY;
            result.from_buffer    = 1'b1;
            result.message_length = 8'(asm_length_in);
            asm_source_in         = frdr_pkg::IDLE_SOURCE;
            asm_total_in          = '0;
         end else begin
            result.verdict = frdr_pkg::VERDICT_STORED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_source_ff <= frdr_pkg::IDLE_SOURCE;
         asm_total_ff  <= '0;
         asm_mask_ff   <= '0;
         asm_count_ff  <= '0;
         asm_length_ff <= '0;
      end else if (ctl.commit) begin
         asm_source_ff <= asm_source_in;
         asm_total_ff  <= asm_total_in;
         asm_mask_ff   <= asm_mask_in;
         asm_count_ff  <= asm_count_in;
         asm_length_ff <= asm_length_in;
      end
   end

`ifndef SYNTH
   a_count_matches_mask : assert property (@(posedge clock) disable iff (reset)
      32'(asm_count_ff) == $countones(asm_mask_ff))
      else $error("fragment count disagrees with received mask");
   a_length_in_buffer : assert property (@(posedge clock) disable iff (reset)
      32'(asm_length_ff) <= BufBytes)
      else $error("reassembly length beyond buffer");
`endif

endmodule

[hdl/frame_dedup_reassembler_core.sv]
// Frame dedup / reassembly core: top level with the lookup stage and result register.
// Depends on frdr_pkg, frdr_seq_filter and frdr_asm_tracker.
//
// Usage:
//   req_valid/req_stall/req_data carry one received frame header per transaction
//   (CRC status, source, sequence, fragment index/count, chunk length).
//   rsp_valid/rsp_stall/rsp_data return exactly one verdict per header, in order,
//   telling the payload side whether to clear the buffer, where to write the
//   chunk and where a finished message comes from.
//   A header accepted goes into the lookup stage register; its verdict is registered into rsp_data when it commits.
//   Throughput: one header per cycle while rsp_stall is low. The per-device sequence table is a
//   synchronous memory read when the header is taken and written back in the
//   lookup stage; a bypass register covers a read of the entry written in the
//   same cycle, so back-to-back headers from one device see each other.
//   Reset clears the known bits of the sequence table (flip-flops, at once) and
//   puts the reassembly idle; the table contents need no clearing pass.
//   While rsp_stall holds, the verdict holds in the result register; one more
//   header waits in the lookup stage and then req_stall rises.
module frame_dedup_reassembler_core #(
   parameter int MaxDevices   = frdr_pkg::MAX_DEVICES_DEF,
   parameter int MaxFragments = frdr_pkg::MAX_FRAGMENTS_DEF,
   parameter int ChunkBytes   = frdr_pkg::CHUNK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  frdr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output frdr_pkg::rsp_type rsp_data
);

   logic              s1_valid_ff;
   frdr_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff;
   frdr_pkg::rsp_type rsp_data_ff;

   frdr_pkg::stage_ctl_type ctl;
   frdr_pkg::rsp_type       s1_result;
   logic                    s1_dup;

   assign ctl.commit = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !ctl.commit;
   assign ctl.accept = req_valid && !req_stall;

   frdr_seq_filter #(
      .MaxDevices(MaxDevices)
   ) u_seq_filter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_item (req_data),
      .s1_item  (s1_data_ff),
      .dup      (s1_dup)
   );

   frdr_asm_tracker #(
      .MaxFragments(MaxFragments),
      .ChunkBytes  (ChunkBytes)
   ) u_asm_tracker (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (s1_data_ff),
      .dup    (s1_dup),
      .result (s1_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ctl.accept) begin
         s1_valid_ff <= 1'b1;
      end else if (ctl.commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         s1_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_data_ff <= s1_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !ctl.commit |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("lookup stage lost a held header");
   a_delivery_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.verdict != frdr_pkg::VERDICT_READY)
      |-> !rsp_data_ff.from_buffer && (rsp_data_ff.message_length == 8'd0))
      else $error("delivery fields set without a ready message");
   a_store_verdict : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.store_payload
      |-> (rsp_data_ff.verdict == frdr_pkg::VERDICT_STORED)
       || (rsp_data_ff.verdict == frdr_pkg::VERDICT_READY))
      else $error("payload store on a rejected header");
`endif

endmodule
